// File: rtl/pbuv_pkg.sv
// ----------------------------------------------------------------------------
// Polygon boundary UV mapper package
// Shared widths, register indexes, the CORDIC arctangent table and the
// fixed-point helpers used by the mapper pipeline and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pbuv_pkg;

   localparam int MAX_VERTS     = 1024;
   localparam int VCOUNT_W      = 11;
   localparam int INDEX_W       = 10;
   localparam int EDGE_W        = 10;
   localparam int SHAPE_W       = 2;
   localparam int UV_W          = 17;
   localparam int FRAC_BITS     = 16;
   localparam int WORK_BITS     = 30;
   localparam int CORDIC_STAGES = 18;
   localparam int STAGE_W       = 5;
   localparam int XY_W          = 32;
   localparam int Z_W           = 34;
   localparam int X_START       = 326016437;
   localparam int DIV_BITS      = 32;
   localparam int DIV_W         = 12;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHAPE_MODE   = 1'b1;

   localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE   = 2'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;
   localparam logic [SHAPE_W-1:0] SHAPE_PENTAGON = 2'd3;

   localparam int PIPE_DEPTH = 4 + DIV_BITS + 1 + DIV_BITS + CORDIC_STAGES + 3 + DIV_BITS + 2;

   function automatic logic [31:0] atan_turns(input logic [STAGE_W-1:0] k);
      logic [31:0] a;
      unique case (k)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10680862;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670675;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41721;
         5'd15: a = 32'd20860;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2607;
         5'd19: a = 32'd1303;
         5'd20: a = 32'd651;
         5'd21: a = 32'd325;
         5'd22: a = 32'd162;
         5'd23: a = 32'd81;
         5'd24: a = 32'd40;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd2;
         5'd29: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // Rounds a work value to the output grid, ties up, and clamps to [0, 1.0].
   function automatic logic [UV_W-1:0] to_uv(input logic signed [35:0] w);
      logic signed [35:0] rounded;
      logic [UV_W-1:0]    r;
      rounded = (w + (36'sd1 <<< (WORK_BITS - FRAC_BITS - 1)))
                >>> (WORK_BITS - FRAC_BITS);
      if (rounded < 36'sd0) begin
         r = '0;
      end else if (rounded > (36'sd1 <<< FRAC_BITS)) begin
         r = UV_W'(1 << FRAC_BITS);
      end else begin
         r = rounded[UV_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pbuv_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in one numerator bit, subtracts the
// divisor when it fits and shifts the quotient bit into the low end.
// ----------------------------------------------------------------------------
`default_nettype none

module pbuv_div_cell (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [pbuv_pkg::DIV_W-1:0]    rem_prev,
   input  logic [pbuv_pkg::DIV_BITS-1:0] nq_prev,
   input  logic [pbuv_pkg::DIV_W-1:0]    divisor_prev,
   output logic [pbuv_pkg::DIV_W-1:0]    rem,
   output logic [pbuv_pkg::DIV_BITS-1:0] nq,
   output logic [pbuv_pkg::DIV_W-1:0]    divisor
);
   import pbuv_pkg::*;

   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_BITS-1:0] nq_ff, nq_in;
   logic [DIV_W-1:0]    divisor_ff;
   logic [DIV_W:0]      trial;
   logic                fits;

   always_comb begin
      trial  = {rem_prev, nq_prev[DIV_BITS-1]};
      fits   = trial >= {1'b0, divisor_prev};
      rem_in = fits ? DIV_W'(trial - {1'b0, divisor_prev}) : trial[DIV_W-1:0];
      nq_in  = {nq_prev[DIV_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff     <= rem_in;
         nq_ff      <= nq_in;
         divisor_ff <= divisor_prev;
      end
   end

   assign rem     = rem_ff;
   assign nq      = nq_ff;
   assign divisor = divisor_ff;

endmodule

`default_nettype wire

// File: rtl/pbuv_divider.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// A chain of divider cells giving a full quotient word and the remainder.
// The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pbuv_divider (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [pbuv_pkg::DIV_W-1:0]    rem_init,
   input  logic [pbuv_pkg::DIV_BITS-1:0] low_word,
   input  logic [pbuv_pkg::DIV_W-1:0]    divisor,
   output logic [pbuv_pkg::DIV_BITS-1:0] quotient,
   output logic [pbuv_pkg::DIV_W-1:0]    remainder
);
   import pbuv_pkg::*;

   logic [DIV_W-1:0]    rem_w [DIV_BITS+1];
   logic [DIV_BITS-1:0] nq_w  [DIV_BITS+1];
   logic [DIV_W-1:0]    div_w [DIV_BITS+1];

   assign rem_w[0] = rem_init;
   assign nq_w[0]  = low_word;
   assign div_w[0] = divisor;

   for (genvar g = 0; g < DIV_BITS; g++) begin : g_cell
      pbuv_div_cell u_cell (
         .clock        (clock),
         .enable       (enable),
         .rem_prev     (rem_w[g]),
         .nq_prev      (nq_w[g]),
         .divisor_prev (div_w[g]),
         .rem          (rem_w[g+1]),
         .nq           (nq_w[g+1]),
         .divisor      (div_w[g+1])
      );
   end

   assign quotient  = nq_w[DIV_BITS];
   assign remainder = rem_w[DIV_BITS];

endmodule

`default_nettype wire

// File: rtl/pbuv_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation with floor shifts and the turn-based
// arctangent of its stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pbuv_cordic_cell (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [pbuv_pkg::STAGE_W-1:0]        stage,
   input  logic signed [pbuv_pkg::XY_W-1:0]    x_prev,
   input  logic signed [pbuv_pkg::XY_W-1:0]    y_prev,
   input  logic signed [pbuv_pkg::Z_W-1:0]     z_prev,
   input  logic                               flip_prev,
   output logic signed [pbuv_pkg::XY_W-1:0]    x,
   output logic signed [pbuv_pkg::XY_W-1:0]    y,
   output logic signed [pbuv_pkg::Z_W-1:0]     z,
   output logic                               flip
);
   import pbuv_pkg::*;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]  z_ff, z_in, angle;
   logic                   flip_ff;

   always_comb begin
      xs    = x_prev >>> stage;
      ys    = y_prev >>> stage;
      angle = $signed({2'b00, atan_turns(stage)});
      if (!z_prev[Z_W-1]) begin
         x_in = x_prev - ys;
         y_in = y_prev + xs;
         z_in = z_prev - angle;
      end else begin
         x_in = x_prev + ys;
         y_in = y_prev - xs;
         z_in = z_prev + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         flip_ff <= flip_prev;
      end
   end

   assign x    = x_ff;
   assign y    = y_ff;
   assign z    = z_ff;
   assign flip = flip_ff;

endmodule

`default_nettype wire

// File: rtl/pbuv_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC chain
// Turns a phase in turns into a corner point of radius one half. Phases in
// the second and third quadrant are rotated by half a turn and negated after.
// ----------------------------------------------------------------------------
`default_nettype none

module pbuv_cordic (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [31:0]                     phase,
   output logic signed [pbuv_pkg::XY_W-1:0] corner_x,
   output logic signed [pbuv_pkg::XY_W-1:0] corner_y
);
   import pbuv_pkg::*;

   logic signed [XY_W-1:0] x_w [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] y_w [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  z_w [CORDIC_STAGES+1];
   logic                   flip_w [CORDIC_STAGES+1];
   logic [31:0]            turned;

   always_comb begin
      flip_w[0] = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      turned    = flip_w[0] ? phase - 32'h8000_0000 : phase;
      z_w[0]    = $signed({{2{turned[31]}}, turned});
      x_w[0]    = XY_W'(X_START);
      y_w[0]    = '0;
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      pbuv_cordic_cell u_cell (
         .clock     (clock),
         .enable    (enable),
         .stage     (STAGE_W'(g)),
         .x_prev    (x_w[g]),
         .y_prev    (y_w[g]),
         .z_prev    (z_w[g]),
         .flip_prev (flip_w[g]),
         .x         (x_w[g+1]),
         .y         (y_w[g+1]),
         .z         (z_w[g+1]),
         .flip      (flip_w[g+1])
      );
   end

   assign corner_x = flip_w[CORDIC_STAGES] ? -x_w[CORDIC_STAGES] : x_w[CORDIC_STAGES];
   assign corner_y = flip_w[CORDIC_STAGES] ? -y_w[CORDIC_STAGES] : y_w[CORDIC_STAGES];

endmodule

`default_nettype wire

// File: rtl/polygon_boundary_uv_mapper.sv
// ----------------------------------------------------------------------------
// Polygon boundary UV mapper
// Places a boundary vertex on a regular polygon inscribed in the circle of
// radius one half around (0.5, 0.5) and returns its UV position.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  vertex_index
//   rsp      out        rsp_valid/rsp_stall  u, v, edge number, index error
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// One request enters per cycle while req is not stalled. The pipeline is built
// from 32-cell divider chains for the index, the phases and the steps and from
// 18-cell CORDIC chains. A two-entry output buffer takes results while
// rsp is stalled, and req stalls only when that buffer is full.
// Reset clears the pipeline valids and loads four vertices in circle mode.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_boundary_uv_mapper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pbuv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pbuv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pbuv_pkg::INDEX_W-1:0]         req_vertex_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pbuv_pkg::UV_W-1:0]            rsp_u_coord,
   output logic [pbuv_pkg::UV_W-1:0]            rsp_v_coord,
   output logic [pbuv_pkg::EDGE_W-1:0]          rsp_edge_number,
   output logic                                rsp_index_error
);
   import pbuv_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0]  ebase;
      logic [VCOUNT_W-1:0] sides;
      logic [VCOUNT_W-1:0] n;
      logic                err;
   } idx_side_type;

   typedef struct packed {
      logic [EDGE_W-1:0]   e;
      logic [VCOUNT_W-1:0] i;
      logic [VCOUNT_W-1:0] n;
      logic                err;
   } corner_side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] c0x;
      logic signed [XY_W-1:0] c0y;
      logic                   negx;
      logic                   negy;
      logic [EDGE_W-1:0]      e;
      logic                   err;
   } step_side_type;

   typedef struct packed {
      logic [UV_W-1:0]   u;
      logic [UV_W-1:0]   v;
      logic [EDGE_W-1:0] e;
      logic              err;
   } result_type;

   localparam int CORNER_LAT = DIV_BITS + CORDIC_STAGES;

   logic adv, push, pop;

   // Configuration registers.
   logic [VCOUNT_W-1:0] vcount_ff;
   logic [SHAPE_W-1:0]  shape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_W'(4);
         shape_ff  <= SHAPE_CIRCLE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_VERTEX_COUNT: vcount_ff <= csr_wdata[VCOUNT_W-1:0];
            REG_SHAPE_MODE:   shape_ff  <= csr_wdata[SHAPE_W-1:0];
            default:          vcount_ff <= vcount_ff;
         endcase
      end
   end

   logic [PIPE_DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // Stage A: capture request and clamped count.
   logic [INDEX_W-1:0]  a_k_ff;
   logic [VCOUNT_W-1:0] a_v_ff;
   logic [SHAPE_W-1:0]  a_shape_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_k_ff     <= req_vertex_index;
         a_v_ff     <= (vcount_ff > VCOUNT_W'(MAX_VERTS)) ? VCOUNT_W'(MAX_VERTS) : vcount_ff;
         a_shape_ff <= shape_ff;
      end
   end

   // Stage B: corner count and points per edge.
   logic [VCOUNT_W-1:0] b_sides, b_q;
   logic                b_small;
   logic [23:0]         b_prod3, b_prod5;
   logic [INDEX_W-1:0]  b_k_ff;
   logic [VCOUNT_W-1:0] b_v_ff, b_sides_ff, b_q_ff;
   logic                b_err_ff;

   always_comb begin
      b_sides = VCOUNT_W'(a_shape_ff) + VCOUNT_W'(2);
      b_small = (a_shape_ff != SHAPE_CIRCLE) && (b_sides < a_v_ff);
      b_prod3 = 24'(a_v_ff) * 24'd2731;
      b_prod5 = 24'(a_v_ff) * 24'd1639;
      b_q     = VCOUNT_W'(1);
      if (b_small) begin
         unique case (a_shape_ff)
            SHAPE_TRIANGLE: b_q = VCOUNT_W'(b_prod3 >> 13);
            SHAPE_SQUARE:   b_q = a_v_ff >> 2;
            SHAPE_PENTAGON: b_q = VCOUNT_W'(b_prod5 >> 13);
            default:        b_q = VCOUNT_W'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_k_ff     <= a_k_ff;
         b_v_ff     <= a_v_ff;
         b_sides_ff <= b_small ? b_sides : a_v_ff;
         b_q_ff     <= b_q;
         b_err_ff   <= {1'b0, a_k_ff} >= a_v_ff;
      end
   end

   // Stage C: edges that carry one extra point.
   logic [INDEX_W-1:0]  c_k_ff;
   logic [VCOUNT_W-1:0] c_sides_ff, c_q_ff, c_r_ff;
   logic                c_err_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c_k_ff     <= b_k_ff;
         c_sides_ff <= b_sides_ff;
         c_q_ff     <= b_q_ff;
         c_r_ff     <= b_v_ff - VCOUNT_W'(b_q_ff * b_sides_ff);
         c_err_ff   <= b_err_ff;
      end
   end

   // Stage D: pick the edge group and set up the index division.
   logic [VCOUNT_W-1:0] d_big;
   logic                d_lt;
   logic [INDEX_W-1:0]  d_num_ff;
   idx_side_type        d_side_ff;

   always_comb begin
      d_big = VCOUNT_W'(c_r_ff * (c_q_ff + VCOUNT_W'(1)));
      d_lt  = {1'b0, c_k_ff} < d_big;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_num_ff        <= d_lt ? c_k_ff : INDEX_W'({1'b0, c_k_ff} - d_big);
         d_side_ff.ebase <= d_lt ? '0 : INDEX_W'(c_r_ff);
         d_side_ff.sides <= c_sides_ff;
         d_side_ff.n     <= d_lt ? c_q_ff + VCOUNT_W'(1) : c_q_ff;
         d_side_ff.err   <= c_err_ff;
      end
   end

   logic [DIV_BITS-1:0] idx_quot;
   logic [DIV_W-1:0]    idx_rem;

   pbuv_divider u_idx_div (
      .clock     (clock),
      .enable    (adv),
      .rem_init  ('0),
      .low_word  (DIV_BITS'(d_num_ff)),
      .divisor   (DIV_W'(d_side_ff.n)),
      .quotient  (idx_quot),
      .remainder (idx_rem)
   );

   idx_side_type idx_line_ff [DIV_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_line_ff[0] <= d_side_ff;
         for (int j = 1; j < DIV_BITS; j++) begin
            idx_line_ff[j] <= idx_line_ff[j-1];
         end
      end
   end

   // Stage F: edge, its successor and the point number on the edge.
   idx_side_type        f_src;
   logic [EDGE_W-1:0]   f_e;
   logic [EDGE_W-1:0]   f_e_ff, f_e1_ff;
   logic [VCOUNT_W-1:0] f_sides_ff;
   corner_side_type     f_side_ff;

   always_comb begin
      f_src = idx_line_ff[DIV_BITS-1];
      f_e   = f_src.ebase + idx_quot[EDGE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_e_ff        <= f_e;
         f_e1_ff       <= ({1'b0, f_e} + VCOUNT_W'(1) == f_src.sides) ? '0 : f_e + EDGE_W'(1);
         f_sides_ff    <= f_src.sides;
         f_side_ff.e   <= f_e;
         f_side_ff.i   <= idx_rem[VCOUNT_W-1:0] + VCOUNT_W'(1);
         f_side_ff.n   <= f_src.n;
         f_side_ff.err <= f_src.err;
      end
   end

   logic [DIV_BITS-1:0] phase0, phase1;
   logic [DIV_W-1:0]    phase0_rem, phase1_rem;

   pbuv_divider u_phase0_div (
      .clock     (clock),
      .enable    (adv),
      .rem_init  (DIV_W'(f_e_ff)),
      .low_word  ('0),
      .divisor   (DIV_W'(f_sides_ff)),
      .quotient  (phase0),
      .remainder (phase0_rem)
   );

   pbuv_divider u_phase1_div (
      .clock     (clock),
      .enable    (adv),
      .rem_init  (DIV_W'(f_e1_ff)),
      .low_word  ('0),
      .divisor   (DIV_W'(f_sides_ff)),
      .quotient  (phase1),
      .remainder (phase1_rem)
   );

   logic signed [XY_W-1:0] c0x, c0y, c1x, c1y;

   pbuv_cordic u_corner0 (
      .clock    (clock),
      .enable   (adv),
      .phase    (phase0),
      .corner_x (c0x),
      .corner_y (c0y)
   );

   pbuv_cordic u_corner1 (
      .clock    (clock),
      .enable   (adv),
      .phase    (phase1),
      .corner_x (c1x),
      .corner_y (c1y)
   );

   corner_side_type corner_line_ff [CORNER_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         corner_line_ff[0] <= f_side_ff;
         for (int j = 1; j < CORNER_LAT; j++) begin
            corner_line_ff[j] <= corner_line_ff[j-1];
         end
      end
   end

   // Stage G: corner differences.
   logic signed [XY_W:0]   g_dx_ff, g_dy_ff;
   logic signed [XY_W-1:0] g_c0x_ff, g_c0y_ff;
   corner_side_type        g_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         g_dx_ff   <= (XY_W+1)'(c1x) - (XY_W+1)'(c0x);
         g_dy_ff   <= (XY_W+1)'(c1y) - (XY_W+1)'(c0y);
         g_c0x_ff  <= c0x;
         g_c0y_ff  <= c0y;
         g_side_ff <= corner_line_ff[CORNER_LAT-1];
      end
   end

   // Stage H: difference times point number.
   logic signed [44:0]     h_tx_ff, h_ty_ff;
   logic signed [XY_W-1:0] h_c0x_ff, h_c0y_ff;
   corner_side_type        h_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         h_tx_ff   <= g_dx_ff * $signed({1'b0, g_side_ff.i});
         h_ty_ff   <= g_dy_ff * $signed({1'b0, g_side_ff.i});
         h_c0x_ff  <= g_c0x_ff;
         h_c0y_ff  <= g_c0y_ff;
         h_side_ff <= g_side_ff;
      end
   end

   // Stage I: rounded floor division set up on magnitudes.
   logic signed [45:0] i_ax, i_ay, i_nterm, i_bias;
   logic [43:0]        i_numx_ff, i_numy_ff;
   logic [DIV_W-1:0]   i_div_ff;
   step_side_type      i_side_ff;

   always_comb begin
      i_nterm = $signed(46'(h_side_ff.n));
      i_bias  = $signed(46'({h_side_ff.n, 1'b0})) - 46'sd1;
      i_ax    = $signed({h_tx_ff, 1'b0}) + i_nterm;
      i_ay    = $signed({h_ty_ff, 1'b0}) + i_nterm;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i_numx_ff      <= i_ax[45] ? 44'(i_bias - i_ax) : 44'(i_ax);
         i_numy_ff      <= i_ay[45] ? 44'(i_bias - i_ay) : 44'(i_ay);
         i_div_ff       <= {h_side_ff.n, 1'b0};
         i_side_ff.c0x  <= h_c0x_ff;
         i_side_ff.c0y  <= h_c0y_ff;
         i_side_ff.negx <= i_ax[45];
         i_side_ff.negy <= i_ay[45];
         i_side_ff.e    <= h_side_ff.e;
         i_side_ff.err  <= h_side_ff.err;
      end
   end

   logic [DIV_BITS-1:0] stepx_quot, stepy_quot;
   logic [DIV_W-1:0]    stepx_rem, stepy_rem;

   pbuv_divider u_stepx_div (
      .clock     (clock),
      .enable    (adv),
      .rem_init  (i_numx_ff[43:32]),
      .low_word  (i_numx_ff[31:0]),
      .divisor   (i_div_ff),
      .quotient  (stepx_quot),
      .remainder (stepx_rem)
   );

   pbuv_divider u_stepy_div (
      .clock     (clock),
      .enable    (adv),
      .rem_init  (i_numy_ff[43:32]),
      .low_word  (i_numy_ff[31:0]),
      .divisor   (i_div_ff),
      .quotient  (stepy_quot),
      .remainder (stepy_rem)
   );

   step_side_type step_line_ff [DIV_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         step_line_ff[0] <= i_side_ff;
         for (int j = 1; j < DIV_BITS; j++) begin
            step_line_ff[j] <= step_line_ff[j-1];
         end
      end
   end

   // Stage J: point position.
   step_side_type      j_src;
   logic signed [33:0] j_qx, j_qy;
   logic signed [33:0] j_px_ff, j_py_ff;
   logic [EDGE_W-1:0]  j_e_ff;
   logic               j_err_ff;

   always_comb begin
      j_src = step_line_ff[DIV_BITS-1];
      j_qx  = j_src.negx ? -$signed({2'b00, stepx_quot}) : $signed({2'b00, stepx_quot});
      j_qy  = j_src.negy ? -$signed({2'b00, stepy_quot}) : $signed({2'b00, stepy_quot});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         j_px_ff  <= $signed({{2{j_src.c0x[XY_W-1]}}, j_src.c0x}) + j_qx;
         j_py_ff  <= $signed({{2{j_src.c0y[XY_W-1]}}, j_src.c0y}) + j_qy;
         j_e_ff   <= j_src.e;
         j_err_ff <= j_src.err;
      end
   end

   // Stage K: turn, offset and round to UV.
   logic signed [35:0] k_half, k_wu, k_wv;
   result_type         k_res_ff;

   always_comb begin
      k_half = 36'sd1 <<< (WORK_BITS - 1);
      k_wu   = k_half - $signed({{2{j_py_ff[33]}}, j_py_ff});
      k_wv   = k_half + $signed({{2{j_px_ff[33]}}, j_px_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_res_ff.u   <= j_err_ff ? '0 : to_uv(k_wu);
         k_res_ff.v   <= j_err_ff ? '0 : to_uv(k_wv);
         k_res_ff.e   <= j_err_ff ? '0 : j_e_ff;
         k_res_ff.err <= j_err_ff;
      end
   end

   // Output buffer.
   result_type ob_ff [2];
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;

   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign adv       = (count_ff != 2'd2) || pop;
   assign push      = adv && valid_ff[PIPE_DEPTH-1];
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ob_ff[wr_ptr_ff] <= k_res_ff;
      end
   end

   assign rsp_u_coord     = ob_ff[rd_ptr_ff].u;
   assign rsp_v_coord     = ob_ff[rd_ptr_ff].v;
   assign rsp_edge_number = ob_ff[rd_ptr_ff].e;
   assign rsp_index_error = ob_ff[rd_ptr_ff].err;

endmodule

`default_nettype wire

// File: rtl/pbuv_port_check.sv
// ----------------------------------------------------------------------------
// Polygon boundary UV mapper port checks
// Assertions on the top-level ports, bound to every mapper instance.
// ----------------------------------------------------------------------------
`default_nettype none

module pbuv_port_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [pbuv_pkg::UV_W-1:0]    rsp_u_coord,
   input logic [pbuv_pkg::UV_W-1:0]    rsp_v_coord,
   input logic [pbuv_pkg::EDGE_W-1:0]  rsp_edge_number,
   input logic                        rsp_index_error
);
   import pbuv_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while no response is buffered");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |->
         rsp_u_coord == '0 && rsp_v_coord == '0 && rsp_edge_number == '0)
      else $error("flagged response carries a nonzero position");

   a_uv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_u_coord <= UV_W'(1 << FRAC_BITS) &&
                    rsp_v_coord <= UV_W'(1 << FRAC_BITS))
      else $error("UV coordinate above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_u_coord) &&
                                 $stable(rsp_v_coord))
      else $error("stalled response changed");

endmodule

bind polygon_boundary_uv_mapper pbuv_port_check u_port_check (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_u_coord     (rsp_u_coord),
   .rsp_v_coord     (rsp_v_coord),
   .rsp_edge_number (rsp_edge_number),
   .rsp_index_error (rsp_index_error)
);

`default_nettype wire
